@@ rtl/core/bubq_pkg.sv @@
`timescale 1ns / 1ps

package bubq_pkg;

    // Bitmap store size in 32-bit words
    localparam int BITMAP_WORDS = 65536;
    localparam int WADDR_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    // Field widths
    localparam int SECT_W    = 48;
    localparam int BLK_W     = 32;
    localparam int CSS_W     = 3;
    localparam int BSS_W     = 4;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int WIDX_W    = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 4;

    // Cluster count covered by the store
    localparam logic [SECT_W-1:0] CLU_LIMIT = SECT_W'(longint'(BITMAP_WORDS) * WORD_W);

    typedef enum logic [0:0] {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OUTSIDE = 2'd0,
        ST_UNUSED  = 2'd1,
        ST_USED    = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SECTOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_SECTOR  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLU_SHIFT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BLK_SHIFT   = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [CSS_W-1:0] CSS_RESET = CSS_W'(1);
    localparam logic [BSS_W-1:0] BSS_RESET = BSS_W'(11);

endpackage

@@ rtl/core/bubq_cfg_if.sv @@
`timescale 1ns / 1ps

interface bubq_cfg_if;
    import bubq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SECT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/bubq_req_if.sv @@
`timescale 1ns / 1ps

interface bubq_req_if;
    import bubq_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;
    logic [BLK_W-1:0]  block_index;

    modport source (output valid, action, word_index, word_data, block_index, input ready);
    modport sink   (input valid, action, word_index, word_data, block_index, output ready);
endinterface

@@ rtl/core/bubq_rsp_if.sv @@
`timescale 1ns / 1ps

interface bubq_rsp_if;
    import bubq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] usage_status;

    modport source (output valid, usage_status, input ready);
    modport sink   (input valid, usage_status, output ready);
endinterface

@@ rtl/core/block_usage_bitmap_query_unit.sv @@
`timescale 1ns / 1ps

// Block usage query unit. Load beats write one 32-bit word of the cluster
// allocation bitmap into an on-chip RAM; they give no result. A query beat
// maps a disk block to its sector range, checks it against the volume base
// and end sectors, turns it into a cluster range rounded outward, and scans
// the bitmap words of that range for a set bit. The RAM read port delivers
// one word per cycle and sets the scan time. A query that falls outside the
// volume or past the bitmap answers without a scan. One item is in work at
// a time; a finished result waits in an output register, so the next item
// is taken while it is pending. Configuration writes are always ready and
// must be issued only while the unit is idle.
module block_usage_bitmap_query_unit (
    input  logic          clk,
    input  logic          rst_n,
    bubq_cfg_if.sink      cfg,
    bubq_req_if.sink      req,
    bubq_rsp_if.source    rsp
);
    import bubq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADDR  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_CLU   = 8'b0000_1000,
        S_RNG   = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [SECT_W-1:0] base_reg, end_sect_reg;
    logic [CSS_W-1:0]  css_reg;
    logic [BSS_W-1:0]  bss_reg;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [SECT_W-1:0]  start_reg, start_next;
    logic [SECT_W-1:0]  stop_reg, stop_next;
    logic [SECT_W-1:0]  rel_start_reg, rel_start_next;
    logic [SECT_W-1:0]  rel_end_reg, rel_end_next;
    logic [SECT_W-1:0]  first_reg, first_next;
    logic [SECT_W-1:0]  lastq_reg, lastq_next;
    logic               round_reg, round_next;
    logic               outside_reg, outside_next;
    logic [WADDR_W-1:0] wfirst_reg, wfirst_next;
    logic [WADDR_W-1:0] wlast_reg, wlast_next;
    logic [WADDR_W-1:0] w_reg, w_next;
    logic [BIT_W-1:0]   fbit_reg, fbit_next;
    logic [BIT_W-1:0]   lbit_reg, lbit_next;
    logic               hit_reg, hit_next;
    logic               rd_v_reg, rd_v_next;
    logic               rd_first_reg, rd_first_next;
    logic               rd_last_reg, rd_last_next;
    logic               rsp_valid_reg, rsp_valid_next;
    status_t            status_reg, status_next;

    // Handshake and RAM signals
    logic               req_acc;
    logic               ram_we;
    logic               ram_re;
    logic [WORD_W-1:0]  ram_rdata;

    // Datapath intermediates
    logic [SECT_W-1:0]  blk_ext;
    logic [SECT_W:0]    diff_start, diff_end, diff_lim;
    logic [SECT_W-1:0]  clu_mask;
    logic [SECT_W-1:0]  last_m1;
    logic               past_store;
    logic [WORD_W-1:0]  lo_mask, hi_mask;
    logic               word_hit;
    status_t            status_calc;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.usage_status = status_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            end_sect_reg <= '0;
            css_reg      <= CSS_RESET;
            bss_reg      <= BSS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_BASE_SECTOR: base_reg     <= cfg.data;
                REG_END_SECTOR:  end_sect_reg <= cfg.data;
                REG_CLU_SHIFT:   css_reg      <= cfg.data[CSS_W-1:0];
                REG_BLK_SHIFT:   bss_reg      <= cfg.data[BSS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Bitmap RAM: loads write at acceptance, the scan reads one word a cycle
    assign ram_we = req_acc && (req.action == ACT_LOAD)
                    && (32'(req.word_index) < 32'(BITMAP_WORDS));
    assign ram_re = (state_reg == S_SCAN);

    bubq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (WADDR_W'(req.word_index)),
        .wdata (req.word_data),
        .re    (ram_re),
        .raddr (w_reg),
        .rdata (ram_rdata)
    );

    // Sector and cluster arithmetic
    assign blk_ext    = SECT_W'(blk_reg);
    assign diff_start = {1'b0, start_reg} - {1'b0, base_reg};
    assign diff_end   = {1'b0, stop_reg} - {1'b0, base_reg};
    assign diff_lim   = {1'b0, end_sect_reg} - {1'b0, stop_reg};
    assign clu_mask   = ~({SECT_W{1'b1}} << css_reg);
    assign last_m1    = round_reg ? lastq_reg : (lastq_reg - SECT_W'(1));
    assign past_store = (lastq_reg > CLU_LIMIT) || ((lastq_reg == CLU_LIMIT) && round_reg);

    // Edge masks for the word coming back from the RAM
    assign lo_mask  = rd_first_reg ? ({WORD_W{1'b1}} << fbit_reg) : {WORD_W{1'b1}};
    assign hi_mask  = rd_last_reg ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lbit_reg))
                                  : {WORD_W{1'b1}};
    assign word_hit = rd_v_reg && (|(ram_rdata & lo_mask & hi_mask));

    assign status_calc = outside_reg ? ST_OUTSIDE : (hit_reg ? ST_USED : ST_UNUSED);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        rel_start_next = rel_start_reg;
        rel_end_next   = rel_end_reg;
        first_next     = first_reg;
        lastq_next     = lastq_reg;
        round_next     = round_reg;
        outside_next   = outside_reg;
        wfirst_next    = wfirst_reg;
        wlast_next     = wlast_reg;
        w_next         = w_reg;
        fbit_next      = fbit_reg;
        lbit_next      = lbit_reg;
        hit_next       = hit_reg || word_hit;
        rd_v_next      = 1'b0;
        rd_first_next  = rd_first_reg;
        rd_last_next   = rd_last_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc && (req.action == ACT_QUERY))
                begin
                    blk_next     = req.block_index;
                    hit_next     = 1'b0;
                    outside_next = 1'b0;
                    state_next   = S_ADDR;
                end
            end
            S_ADDR:
            begin
                start_next = blk_ext << bss_reg;
                stop_next  = (blk_ext << bss_reg) + (SECT_W'(1) << bss_reg);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // borrow bits give start < base and end > volume end
                outside_next   = diff_start[SECT_W] || diff_lim[SECT_W];
                rel_start_next = diff_start[SECT_W-1:0];
                rel_end_next   = diff_end[SECT_W-1:0];
                state_next     = (diff_start[SECT_W] || diff_lim[SECT_W]) ? S_OUT : S_CLU;
            end
            S_CLU:
            begin
                first_next = rel_start_reg >> css_reg;
                lastq_next = rel_end_reg >> css_reg;
                round_next = |(rel_end_reg & clu_mask);
                state_next = S_RNG;
            end
            S_RNG:
            begin
                wfirst_next = first_reg[WADDR_W+BIT_W-1:BIT_W];
                wlast_next  = last_m1[WADDR_W+BIT_W-1:BIT_W];
                w_next      = first_reg[WADDR_W+BIT_W-1:BIT_W];
                fbit_next   = first_reg[BIT_W-1:0];
                lbit_next   = last_m1[BIT_W-1:0];
                if (past_store)
                begin
                    outside_next = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_v_next     = 1'b1;
                rd_first_next = (w_reg == wfirst_reg);
                rd_last_next  = (w_reg == wlast_reg);
                if (w_reg == wlast_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    w_next = w_reg + WADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                // last word is folded into the hit flag at this edge
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = status_calc;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_v_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_v_reg      <= rd_v_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        start_reg     <= start_next;
        stop_reg      <= stop_next;
        rel_start_reg <= rel_start_next;
        rel_end_reg   <= rel_end_next;
        first_reg     <= first_next;
        lastq_reg     <= lastq_next;
        round_reg     <= round_next;
        outside_reg   <= outside_next;
        wfirst_reg    <= wfirst_next;
        wlast_reg     <= wlast_next;
        w_reg         <= w_next;
        fbit_reg      <= fbit_next;
        lbit_reg      <= lbit_next;
        hit_reg       <= hit_next;
        rd_first_reg  <= rd_first_next;
        rd_last_reg   <= rd_last_next;
        status_reg    <= status_next;
    end

endmodule

@@ rtl/core/bubq_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module bubq_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/bubq_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks for the block usage query unit
module bubq_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        req_action,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [bubq_pkg::STAT_W-1:0] rsp_usage_status
);
    import bubq_pkg::*;

    // A pending result beat holds its status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_usage_status))
        else $error("result beat changed while stalled");

    // Status is always one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_usage_status == ST_OUTSIDE || rsp_usage_status == ST_UNUSED
                       || rsp_usage_status == ST_USED))
        else $error("illegal usage status");

    // A load beat produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_LOAD) && !rsp_valid |=> !rsp_valid)
        else $error("load beat produced a result");

    // A query beat blocks the input and has no result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_QUERY) && !rsp_valid
        |=> !rsp_valid && !req_ready)
        else $error("query beat answered too early");

endmodule

bind block_usage_bitmap_query_unit bubq_checker u_bubq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_action       (req.action),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_usage_status (rsp.usage_status)
);
